// ----- hdl/msg_pkg.sv -----
// shared types and constants for the multi-stop gradient pixel unit
// no dependencies; every other file uses this package by scoped names
`default_nettype none

package msg_pkg;

	localparam int unsigned MAX_STOPS = 8;
	localparam int unsigned MAX_SPAN  = 4096;

	localparam int unsigned IDX_W = 3;
	localparam int unsigned POS_W = 12;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned LEN_W = 13;
	localparam int unsigned T_W   = 15;   // pos * (stops - 1)
	localparam int unsigned SEG_W = 3;
	localparam int unsigned NUM_W = 20;   // |delta| * remainder
	localparam int unsigned CH_W  = 8;
	localparam int unsigned LANES = 4;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic [1:0] REG_STOP_COUNT    = 2'd0;
	localparam logic [1:0] REG_SPAN_LENGTH   = 2'd1;
	localparam logic [1:0] REG_ROUNDING_MODE = 2'd2;

	localparam logic [CNT_W-1:0] STOP_COUNT_RST = 4'd2;
	localparam logic [LEN_W-1:0] SPAN_RST       = 13'd256;

	typedef struct packed {
		logic                              cmd;
		logic [IDX_W-1:0]                  idx;
		logic [LANES*CH_W-1:0]             color;
		logic                              oor;
		logic                              mode;
		logic [LEN_W-1:0]                  len;
		logic [T_W-1:0]                    rem1;
		logic [SEG_W-1:0]                  seg;
		logic [LANES-1:0][CH_W-1:0]        lo;
		logic [LANES-1:0][CH_W-1:0]        hi;
		logic [LANES-1:0][NUM_W-1:0]       num;
		logic [LANES-1:0][CH_W-1:0]        q;
		logic [LANES-1:0]                  neg;
	} item_t;

endpackage

`default_nettype wire

// ----- hdl/msg_seg_cell.sv -----
// one bit of the segment division t / len, one cell of the segment chain
// depends on msg_pkg
`default_nettype none

module msg_seg_cell #(
	parameter int unsigned BIT = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire msg_pkg::item_t up_item,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output msg_pkg::item_t     dn_item
);

	localparam int unsigned CW = msg_pkg::T_W + 1;

	logic           valid_q;
	msg_pkg::item_t item_q;
	msg_pkg::item_t nxt;
	logic [CW-1:0]  dv;
	logic [CW-1:0]  rem;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_item  = item_q;

	always_comb begin
		nxt = up_item;
		dv  = CW'(up_item.len) << BIT;
		rem = CW'(up_item.rem1);
		if (rem >= dv) begin
			nxt.rem1     = msg_pkg::T_W'(rem - dv);
			nxt.seg[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			item_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/msg_stop_stage.sv -----
// stop table: writes commit here in stream order, pixels read both neighbor stops
// depends on msg_pkg
`default_nettype none

module msg_stop_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire msg_pkg::item_t up_item,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output msg_pkg::item_t     dn_item
);

	logic           valid_q;
	msg_pkg::item_t item_q;
	logic [msg_pkg::LANES-1:0][msg_pkg::CH_W-1:0] lo_q;
	logic [msg_pkg::LANES-1:0][msg_pkg::CH_W-1:0] hi_q;
	logic [msg_pkg::LANES*msg_pkg::CH_W-1:0] stop_q [msg_pkg::MAX_STOPS];

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;

	always_comb begin
		dn_item    = item_q;
		dn_item.lo = lo_q;
		dn_item.hi = hi_q;
	end

	// write items end here and make no result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid && (up_item.cmd == msg_pkg::CMD_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			if (up_item.cmd == msg_pkg::CMD_WRITE) begin
				stop_q[up_item.idx] <= up_item.color;
			end
			item_q <= up_item;
			lo_q   <= stop_q[up_item.seg];
			hi_q   <= stop_q[up_item.seg + msg_pkg::SEG_W'(1)];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/msg_mul_cell.sv -----
// per channel delta magnitude times segment remainder, sign kept aside
// depends on msg_pkg
`default_nettype none

module msg_mul_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire msg_pkg::item_t up_item,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output msg_pkg::item_t     dn_item
);

	localparam int unsigned PW = msg_pkg::CH_W + msg_pkg::LEN_W;

	logic           valid_q;
	msg_pkg::item_t item_q;
	msg_pkg::item_t nxt;
	logic [msg_pkg::CH_W-1:0] mag [msg_pkg::LANES];
	logic [PW-1:0]            prod [msg_pkg::LANES];

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_item  = item_q;

	always_comb begin
		nxt = up_item;
		for (int k = 0; k < msg_pkg::LANES; k++) begin
			nxt.neg[k] = up_item.hi[k] < up_item.lo[k];
			mag[k]     = nxt.neg[k] ? (up_item.lo[k] - up_item.hi[k])
			                        : (up_item.hi[k] - up_item.lo[k]);
			prod[k]    = PW'(mag[k]) * PW'(up_item.rem1[msg_pkg::LEN_W-1:0]);
			nxt.num[k] = prod[k][msg_pkg::NUM_W-1:0];
			nxt.q[k]   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			item_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/msg_chan_cell.sv -----
// one quotient bit of num / len for all four channels, one cell of the blend chain
// depends on msg_pkg
`default_nettype none

module msg_chan_cell #(
	parameter int unsigned BIT = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire msg_pkg::item_t up_item,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output msg_pkg::item_t     dn_item
);

	localparam int unsigned CW = msg_pkg::NUM_W + msg_pkg::CH_W;

	logic           valid_q;
	msg_pkg::item_t item_q;
	msg_pkg::item_t nxt;
	logic [CW-1:0]  dv;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_item  = item_q;

	always_comb begin
		nxt = up_item;
		dv  = CW'(up_item.len) << BIT;
		for (int k = 0; k < msg_pkg::LANES; k++) begin
			if (CW'(up_item.num[k]) >= dv) begin
				nxt.num[k]    = msg_pkg::NUM_W'(CW'(up_item.num[k]) - dv);
				nxt.q[k][BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			item_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/multi_stop_gradient_pixel_unit.sv -----
// top level of the multi-stop gradient pixel unit: config registers, cell chain, output
// depends on msg_pkg, msg_seg_cell, msg_stop_stage, msg_mul_cell, msg_chan_cell
//
//   channel   dir   handshake              payload
//   s_axis    in    tvalid/tready          tdata: stop and position, tuser: command
//   m_axis    out   tvalid/tready          tdata: rgba, tuser: out_of_range
//   apb       in    psel/penable/pready    stop_count, span_length, rounding_mode
//
// one item per clock while the output is not stalled; a pixel item passes the cell chain:
// 3 segment division cells, table read, multiply, 8 channel division cells,
// output register
// each cell holds while its neighbor is full, so bubbles close up under stall
// reset clears valid flags and config registers; the stop table is garbage until written
`default_nettype none

module multi_stop_gradient_pixel_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// stop_index, stop_red, stop_green, stop_blue, stop_alpha, pixel_position, zero pad
	input  wire logic [47:0] s_axis_tdata,
	// command
	input  wire logic [0:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// pixel_red, pixel_green, pixel_blue, pixel_alpha
	output logic [31:0]      m_axis_tdata,
	// out_of_range
	output logic [0:0]       m_axis_tuser,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned NCELL = msg_pkg::SEG_W + 2 + msg_pkg::CH_W;

	logic [msg_pkg::CNT_W-1:0] stop_count_q;
	logic [msg_pkg::LEN_W-1:0] span_length_q;
	logic                      rounding_mode_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q    <= msg_pkg::STOP_COUNT_RST;
			span_length_q   <= msg_pkg::SPAN_RST;
			rounding_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				msg_pkg::REG_STOP_COUNT:    stop_count_q    <= pwdata[msg_pkg::CNT_W-1:0];
				msg_pkg::REG_SPAN_LENGTH:   span_length_q   <= pwdata[msg_pkg::LEN_W-1:0];
				msg_pkg::REG_ROUNDING_MODE: rounding_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			msg_pkg::REG_STOP_COUNT:    prdata = 32'(stop_count_q);
			msg_pkg::REG_SPAN_LENGTH:   prdata = 32'(span_length_q);
			msg_pkg::REG_ROUNDING_MODE: prdata = 32'(rounding_mode_q);
			default:                    prdata = '0;
		endcase
	end

	// front end: clamp config, range check, t = pos * (stops - 1)
	logic [msg_pkg::SEG_W-1:0] nm1;
	logic [msg_pkg::LEN_W-1:0] len;
	logic [msg_pkg::POS_W-1:0] pos;
	msg_pkg::item_t            in_item;

	assign pos = s_axis_tdata[46:35];

	always_comb begin
		if (stop_count_q < msg_pkg::CNT_W'(2)) begin
			nm1 = msg_pkg::SEG_W'(1);
		end else if (stop_count_q > msg_pkg::CNT_W'(msg_pkg::MAX_STOPS)) begin
			nm1 = msg_pkg::SEG_W'(msg_pkg::MAX_STOPS - 1);
		end else begin
			nm1 = msg_pkg::SEG_W'(stop_count_q - msg_pkg::CNT_W'(1));
		end
		if (span_length_q > msg_pkg::LEN_W'(msg_pkg::MAX_SPAN)) begin
			len = msg_pkg::LEN_W'(msg_pkg::MAX_SPAN);
		end else begin
			len = span_length_q;
		end
		in_item       = '0;
		in_item.cmd   = s_axis_tuser[0];
		in_item.idx   = s_axis_tdata[2:0];
		in_item.color = s_axis_tdata[34:3];
		in_item.mode  = rounding_mode_q;
		in_item.len   = len;
		in_item.oor   = (len == '0) || (msg_pkg::LEN_W'(pos) >= len);
		in_item.rem1  = msg_pkg::T_W'(pos) * msg_pkg::T_W'(nm1);
	end

	// cell chain
	logic           c_valid [NCELL+1];
	logic           c_ready [NCELL+1];
	msg_pkg::item_t c_item  [NCELL+1];

	assign c_valid[0]    = s_axis_tvalid;
	assign c_item[0]     = in_item;
	assign s_axis_tready = c_ready[0];

	for (genvar g = 0; g < msg_pkg::SEG_W; g++) begin : g_seg
		msg_seg_cell #(.BIT(msg_pkg::SEG_W - 1 - g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.up_valid(c_valid[g]), .up_ready(c_ready[g]), .up_item(c_item[g]),
			.dn_valid(c_valid[g+1]), .dn_ready(c_ready[g+1]), .dn_item(c_item[g+1])
		);
	end

	msg_stop_stage u_stop (
		.clk(clk), .arst_n(arst_n),
		.up_valid(c_valid[msg_pkg::SEG_W]), .up_ready(c_ready[msg_pkg::SEG_W]),
		.up_item(c_item[msg_pkg::SEG_W]),
		.dn_valid(c_valid[msg_pkg::SEG_W+1]), .dn_ready(c_ready[msg_pkg::SEG_W+1]),
		.dn_item(c_item[msg_pkg::SEG_W+1])
	);

	msg_mul_cell u_mul (
		.clk(clk), .arst_n(arst_n),
		.up_valid(c_valid[msg_pkg::SEG_W+1]), .up_ready(c_ready[msg_pkg::SEG_W+1]),
		.up_item(c_item[msg_pkg::SEG_W+1]),
		.dn_valid(c_valid[msg_pkg::SEG_W+2]), .dn_ready(c_ready[msg_pkg::SEG_W+2]),
		.dn_item(c_item[msg_pkg::SEG_W+2])
	);

	for (genvar g = 0; g < msg_pkg::CH_W; g++) begin : g_chan
		localparam int unsigned P = msg_pkg::SEG_W + 2 + g;
		msg_chan_cell #(.BIT(msg_pkg::CH_W - 1 - g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.up_valid(c_valid[P]), .up_ready(c_ready[P]), .up_item(c_item[P]),
			.dn_valid(c_valid[P+1]), .dn_ready(c_ready[P+1]), .dn_item(c_item[P+1])
		);
	end

	// output register: sign, rounding and range flag
	logic                            out_valid_q;
	logic [31:0]                     out_data_q;
	logic                            out_oor_q;
	msg_pkg::item_t                  last;
	logic [msg_pkg::CH_W-1:0]        off  [msg_pkg::LANES];
	logic [msg_pkg::LANES*msg_pkg::CH_W-1:0] color;

	assign last              = c_item[NCELL];
	assign c_ready[NCELL]    = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid     = out_valid_q;
	assign m_axis_tdata      = out_data_q;
	assign m_axis_tuser[0]   = out_oor_q;

	always_comb begin
		for (int k = 0; k < msg_pkg::LANES; k++) begin
			if (last.neg[k]) begin
				// floor steps one further down when the division left a remainder
				off[k] = -last.q[k] - msg_pkg::CH_W'(!last.mode && (last.num[k] != '0));
			end else begin
				off[k] = last.q[k];
			end
			color[k*msg_pkg::CH_W +: msg_pkg::CH_W] = last.oor ? '0 : (last.lo[k] + off[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (c_ready[NCELL]) begin
			out_valid_q <= c_valid[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (c_ready[NCELL] && c_valid[NCELL]) begin
			out_data_q <= color;
			out_oor_q  <= last.oor;
		end
	end

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// testbench for the multi-stop gradient pixel unit: stop writes and pixel computes on the stream port
// depends on msg_pkg and multi_stop_gradient_pixel_unit; models untyped pixels by own colour math
`timescale 1ns / 1ps

module tb;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       oor;
	} pixel_t;

	typedef struct {
		logic       cmd;
		logic [2:0] idx;
		logic [7:0] r, g, b, a;
		logic [11:0] pos;
		bit         typed;
		pixel_t     want;
	} row_t;

	localparam int CYCLE_LIMIT = 600000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	multi_stop_gradient_pixel_unit dut (.*);

	// shadow of the block's state
	logic [7:0]  stop_rgba [msg_pkg::MAX_STOPS][msg_pkg::LANES];
	logic [3:0]  cfg_count;
	logic [12:0] cfg_span;
	logic        cfg_round;

	pixel_t pending_pixels [$];
	int     errors;
	int     idle_pct;
	bit     quiet;
	bit     hold_req;
	int     cycles;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [7:0] lerp_channel(int lo, int hi, int rem, int len, bit floor_it);
		longint num, q;
		num = longint'(hi - lo) * longint'(rem);
		q = num / longint'(len);
		if (floor_it && num < 0 && (num % longint'(len)) != 0)
			q = q - 1;
		return 8'(longint'(lo) + q);
	endfunction

	function automatic pixel_t gradient_color(logic [11:0] pos);
		pixel_t p;
		int n, len, t, seg, rem;
		logic [7:0] ch [msg_pkg::LANES];
		n = cfg_count;
		if (n < 2) n = 2;
		if (n > msg_pkg::MAX_STOPS) n = msg_pkg::MAX_STOPS;
		len = cfg_span;
		if (len > msg_pkg::MAX_SPAN) len = msg_pkg::MAX_SPAN;
		if (len == 0 || pos >= len) begin
			p = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1};
			return p;
		end
		t = int'(pos) * (n - 1);
		seg = t / len;
		rem = t % len;
		if (seg > n - 2) seg = n - 2;
		for (int k = 0; k < msg_pkg::LANES; k++)
			ch[k] = lerp_channel(stop_rgba[seg][k], stop_rgba[seg + 1][k], rem, len,
				cfg_round == 1'b0);
		p = '{ch[0], ch[1], ch[2], ch[3], 1'b0};
		return p;
	endfunction

	task automatic send_item(row_t it);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.cmd;
		s_axis_tdata  <= {1'b0, it.pos, it.a, it.b, it.g, it.r, it.idx};
		do @(posedge clk); while (!s_axis_tready);
		if (it.cmd == msg_pkg::CMD_WRITE) begin
			stop_rgba[it.idx] = '{it.r, it.g, it.b, it.a};
		end else if (it.typed) begin
			pending_pixels.push_back(it.want);
		end else begin
			pending_pixels.push_back(gradient_color(it.pos));
		end
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// drain, then give write items still in the chain time to leave
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] regno, logic [31:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {regno, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (regno)
			msg_pkg::REG_STOP_COUNT:    cfg_count = value[3:0];
			msg_pkg::REG_SPAN_LENGTH:   cfg_span  = value[12:0];
			msg_pkg::REG_ROUNDING_MODE: cfg_round = value[0];
			default: ;
		endcase
	endtask

	task automatic set_gradient(int n, int len, int mode);
		reg_write(msg_pkg::REG_STOP_COUNT, n);
		reg_write(msg_pkg::REG_SPAN_LENGTH, len);
		reg_write(msg_pkg::REG_ROUNDING_MODE, mode);
	endtask

	function automatic row_t random_row();
		row_t it;
		it.cmd = ($urandom_range(0, 3) == 0) ? msg_pkg::CMD_WRITE : msg_pkg::CMD_PIXEL;
		it.idx = 3'($urandom_range(0, 7));
		it.r = 8'($urandom);
		it.g = 8'($urandom);
		it.b = 8'($urandom);
		it.a = 8'($urandom);
		if (cfg_span != 0 && $urandom_range(0, 9) != 0)
			it.pos = 12'($urandom_range(0,
				(cfg_span > msg_pkg::MAX_SPAN ? msg_pkg::MAX_SPAN : cfg_span) - 1));
		else
			it.pos = 12'($urandom);
		it.typed = 1'b0;
		return it;
	endfunction

	// result checker
	always @(posedge clk) begin
		pixel_t w;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel item with none expected");
				errors++;
			end else begin
				w = pending_pixels.pop_front();
				if (m_axis_tdata[7:0] !== w.red) begin
					$error("pixel_red expected %0d got %0d", w.red, m_axis_tdata[7:0]);
					errors++;
				end
				if (m_axis_tdata[15:8] !== w.green) begin
					$error("pixel_green expected %0d got %0d", w.green, m_axis_tdata[15:8]);
					errors++;
				end
				if (m_axis_tdata[23:16] !== w.blue) begin
					$error("pixel_blue expected %0d got %0d", w.blue, m_axis_tdata[23:16]);
					errors++;
				end
				if (m_axis_tdata[31:24] !== w.alpha) begin
					$error("pixel_alpha expected %0d got %0d", w.alpha, m_axis_tdata[31:24]);
					errors++;
				end
				if (m_axis_tuser[0] !== w.oor) begin
					$error("out_of_range expected %0d got %0d", w.oor, m_axis_tuser[0]);
					errors++;
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		row_t  dir [$];
		row_t  it;
		pixel_t zero_oor;
		int    n, len, mode;
		zero_oor = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1};
		quiet = 1'b0;
		hold_req = 1'b0;
		idle_pct = 20;
		cfg_count = msg_pkg::STOP_COUNT_RST;
		cfg_span = msg_pkg::SPAN_RST;
		cfg_round = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings: two stops over 256 pixels, floor rounding
		dir.push_back('{msg_pkg::CMD_WRITE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 12'd0, 1'b0,
			zero_oor});
		dir.push_back('{msg_pkg::CMD_WRITE, 3'd1, 8'hff, 8'hff, 8'hff, 8'hff, 12'd0, 1'b0,
			zero_oor});
		for (int k = 2; k < 8; k++)
			dir.push_back('{msg_pkg::CMD_WRITE, 3'(k), 8'(k * 37), 8'(255 - k * 29),
				8'(k * 11), 8'(k * 53), 12'hfff, 1'b0, zero_oor});
		dir.push_back('{msg_pkg::CMD_PIXEL, 3'd7, 8'hff, 8'hff, 8'hff, 8'hff, 12'd0, 1'b1,
			'{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}});
		dir.push_back('{msg_pkg::CMD_PIXEL, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 12'd256, 1'b1,
			zero_oor});
		dir.push_back('{msg_pkg::CMD_PIXEL, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 12'd4095, 1'b1,
			zero_oor});
		dir.push_back('{msg_pkg::CMD_PIXEL, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 12'd255, 1'b0,
			zero_oor});
		dir.push_back('{msg_pkg::CMD_PIXEL, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 12'd128, 1'b0,
			zero_oor});
		dir.push_back('{msg_pkg::CMD_PIXEL, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 12'd1, 1'b0,
			zero_oor});
		// descending stops give negative deltas for floor rounding
		dir.push_back('{msg_pkg::CMD_WRITE, 3'd0, 8'hff, 8'h80, 8'h01, 8'hfe, 12'd0, 1'b0,
			zero_oor});
		dir.push_back('{msg_pkg::CMD_WRITE, 3'd1, 8'h00, 8'h7f, 8'h00, 8'h01, 12'd0, 1'b0,
			zero_oor});
		dir.push_back('{msg_pkg::CMD_PIXEL, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 12'd3, 1'b0,
			zero_oor});
		dir.push_back('{msg_pkg::CMD_PIXEL, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 12'd200, 1'b0,
			zero_oor});
		foreach (dir[i]) send_item(dir[i]);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin n = 8; len = 4096; mode = 1; end
				1: begin n = 0; len = 1; mode = 0; end
				2: begin n = 15; len = 8191; mode = 1; end
				3: begin n = 1; len = 0; mode = 0; end
				4: begin n = 9; len = 4096; mode = 0; end
				5: begin n = 2; len = 256; mode = 1; end
				default: begin
					n = $urandom_range(2, 8);
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096)
						: $urandom_range(1, 64);
					mode = $urandom_range(0, 1);
				end
			endcase
			set_gradient(n, len, mode);
			@(posedge clk);
			idle_pct = (ph % 3 == 2) ? 0 : $urandom_range(5, 40);
			if (ph == 4) begin
				idle_pct = 0;
				hold_req = 1'b1;
			end
			if (ph >= 10) quiet = 1'b1;
			for (int i = 0; i < 105; i++) begin
				it = random_row();
				send_item(it);
			end
			drain();
		end

		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
